// File: hdl/clsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsq_pkg: shared types and constants for the character lcd nibble sequencer
// Request codes, controller state, command/status groups, the init sequence
// table and the decimal power table.
// ----------------------------------------------------------------------------
package clsq_pkg;

    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_CMD    = 3'd1;
    localparam logic [2:0] REQ_DATA   = 3'd2;
    localparam logic [2:0] REQ_CURSOR = 3'd3;
    localparam logic [2:0] REQ_NUM    = 3'd4;

    localparam logic [3:0] DIGIT_POSITIONS = 4'd10;
    localparam logic [4:0] INIT_LAST_IDX   = 5'd13;
    localparam logic [7:0] DDRAM_SET_ADDR  = 8'h80;
    localparam logic [3:0] ASCII_DIGIT_HI  = 4'h3;

    typedef enum logic [2:0] {
        KIND_INIT,
        KIND_CMD,
        KIND_DATA,
        KIND_CURSOR,
        KIND_NUM,
        KIND_NONE
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic out_load;
        logic next_nib;
    } cmd_t;

    typedef struct packed {
        kind_t in_kind;
        logic  conv_done;
        logic  last_nib;
    } status_t;

    typedef struct packed {
        logic [3:0] nib;
        logic [6:0] wait_ms;
    } init_entry_t;

    function automatic init_entry_t init_rom(input logic [3:0] step);
        init_entry_t e;
        case (step)
            4'd0:    e = '{nib: 4'h3, wait_ms: 7'd115};
            4'd1:    e = '{nib: 4'h3, wait_ms: 7'd5};
            4'd2:    e = '{nib: 4'h3, wait_ms: 7'd5};
            4'd3:    e = '{nib: 4'h2, wait_ms: 7'd5};
            4'd4:    e = '{nib: 4'h2, wait_ms: 7'd1};
            4'd5:    e = '{nib: 4'h8, wait_ms: 7'd0};
            4'd6:    e = '{nib: 4'h0, wait_ms: 7'd1};
            4'd7:    e = '{nib: 4'h8, wait_ms: 7'd0};
            4'd8:    e = '{nib: 4'h0, wait_ms: 7'd1};
            4'd9:    e = '{nib: 4'h1, wait_ms: 7'd0};
            4'd10:   e = '{nib: 4'h0, wait_ms: 7'd5};
            4'd11:   e = '{nib: 4'h6, wait_ms: 7'd0};
            4'd12:   e = '{nib: 4'h0, wait_ms: 7'd1};
            4'd13:   e = '{nib: 4'hC, wait_ms: 7'd0};
            default: e = '{nib: 4'h0, wait_ms: 7'd0};
        endcase
        return e;
    endfunction

    function automatic logic [31:0] pow10(input logic [3:0] pos);
        logic [31:0] p;
        case (pos)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

// File: hdl/clsq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsq_ctrl: sequencer controller
// Accepts one item at a time, runs the decimal conversion when needed and
// steps the datapath through the nibbles of the item.
// ----------------------------------------------------------------------------
module clsq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              res_valid,
    input  logic              res_ready,
    input  clsq_pkg::status_t status,
    output clsq_pkg::cmd_t    cmd
);

    clsq_pkg::state_t state_reg;
    clsq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clsq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            clsq_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (status.in_kind)
                        clsq_pkg::KIND_NONE: state_next = clsq_pkg::ST_IDLE;
                        clsq_pkg::KIND_NUM:  state_next = clsq_pkg::ST_CONV;
                        default:             state_next = clsq_pkg::ST_LOAD;
                    endcase
                end
            end
            clsq_pkg::ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_done)
                begin
                    state_next = clsq_pkg::ST_LOAD;
                end
            end
            clsq_pkg::ST_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = clsq_pkg::ST_SEND;
            end
            clsq_pkg::ST_SEND:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (status.last_nib)
                    begin
                        state_next = clsq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_nib = 1'b1;
                        state_next   = clsq_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = clsq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/clsq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsq_datapath: sequencer datapath
// Request decode, carried wait, digit-by-digit decimal conversion by repeated
// subtraction of powers of ten, and the registered result nibble.
// ----------------------------------------------------------------------------
module clsq_datapath
#(
    parameter int MAX_DIGITS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  clsq_pkg::cmd_t    cmd,
    output clsq_pkg::status_t status,
    input  logic [2:0]        req_type,
    input  logic [7:0]        byte_value,
    input  logic [5:0]        column,
    input  logic [2:0]        row,
    input  logic [3:0]        num_digits,
    input  logic [31:0]       number,
    output logic              reg_select,
    output logic [3:0]        nibble,
    output logic [6:0]        wait_ms,
    output logic              overflow,
    output logic              last
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    clsq_pkg::kind_t kind_reg, kind_next;
    logic            rs_reg, rs_next;
    logic [7:0]      byte_reg, byte_next;
    logic [2:0]      carry_reg, carry_next;
    logic [2:0]      pending_reg, pending_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [4:0]      last_idx_reg, last_idx_next;
    logic [4:0]      nib_reg, nib_next;
    logic [31:0]     rem_reg, rem_next;
    logic [3:0]      pos_reg, pos_next;
    logic [3:0]      acc_reg, acc_next;
    logic            ovf_reg, ovf_next;
    logic [3:0]      digit_reg [MAX_DIGITS];

    logic            out_rs_reg;
    logic [3:0]      out_nib_reg;
    logic [6:0]      out_wait_reg;
    logic            out_ovf_reg;
    logic            out_last_reg;

    clsq_pkg::kind_t      in_kind;
    logic [3:0]           cnt_sat;
    logic [7:0]           line_base;
    logic [7:0]           cursor_byte;
    logic [31:0]          pow_cur;
    logic                 ge;
    logic [3:0]           digit_idx;
    logic [3:0]           cur_digit;
    logic [7:0]           src_byte;
    clsq_pkg::init_entry_t init_e;
    logic                 nx_rs;
    logic [3:0]           nx_nib;
    logic [6:0]           nx_wait;
    logic                 nx_ovf;
    logic                 is_last;

    // request decode
    always_comb
    begin
        cnt_sat = (num_digits > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : num_digits;
        case (req_type)
            clsq_pkg::REQ_INIT:   in_kind = clsq_pkg::KIND_INIT;
            clsq_pkg::REQ_CMD:    in_kind = clsq_pkg::KIND_CMD;
            clsq_pkg::REQ_DATA:   in_kind = clsq_pkg::KIND_DATA;
            clsq_pkg::REQ_CURSOR: in_kind = clsq_pkg::KIND_CURSOR;
            clsq_pkg::REQ_NUM:
                in_kind = (cnt_sat == 4'd0) ? clsq_pkg::KIND_NONE : clsq_pkg::KIND_NUM;
            default:              in_kind = clsq_pkg::KIND_NONE;
        endcase
        case (row)
            3'd2:    line_base = 8'h40;
            3'd3:    line_base = 8'h14;
            3'd4:    line_base = 8'h54;
            default: line_base = 8'h00;
        endcase
        cursor_byte = clsq_pkg::DDRAM_SET_ADDR | (line_base + {2'b00, column} - 8'd1);
    end

    assign pow_cur = clsq_pkg::pow10(pos_reg);
    assign ge      = (rem_reg >= pow_cur);
    assign is_last = (nib_reg == last_idx_reg);

    assign status = '{in_kind:   in_kind,
                      conv_done: (pos_reg == 4'd0) && !ge,
                      last_nib:  is_last};

    // next result nibble
    always_comb
    begin
        digit_idx = cnt_reg - 4'd1 - nib_reg[4:1];
        cur_digit = digit_reg[digit_idx[IDX_W-1:0]];
        src_byte  = (kind_reg == clsq_pkg::KIND_NUM) ? {clsq_pkg::ASCII_DIGIT_HI, cur_digit}
                                                     : byte_reg;
        init_e    = clsq_pkg::init_rom(nib_reg[3:0]);
        if (kind_reg == clsq_pkg::KIND_INIT)
        begin
            nx_rs   = 1'b0;
            nx_nib  = init_e.nib;
            nx_wait = init_e.wait_ms;
            nx_ovf  = 1'b0;
        end
        else
        begin
            nx_rs  = rs_reg;
            nx_nib = nib_reg[0] ? src_byte[3:0] : src_byte[7:4];
            if (nib_reg == 5'd0)
            begin
                nx_wait = 7'd1 + {4'b0000, carry_reg};
            end
            else
            begin
                nx_wait = nib_reg[0] ? 7'd0 : 7'd1;
            end
            nx_ovf = (kind_reg == clsq_pkg::KIND_NUM) && ovf_reg;
        end
    end

    always_comb
    begin
        kind_next     = kind_reg;
        rs_next       = rs_reg;
        byte_next     = byte_reg;
        carry_next    = carry_reg;
        pending_next  = pending_reg;
        cnt_next      = cnt_reg;
        last_idx_next = last_idx_reg;
        nib_next      = nib_reg;
        rem_next      = rem_reg;
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        if (cmd.load)
        begin
            kind_next  = in_kind;
            rs_next    = (in_kind == clsq_pkg::KIND_DATA) || (in_kind == clsq_pkg::KIND_NUM);
            byte_next  = (in_kind == clsq_pkg::KIND_CURSOR) ? cursor_byte : byte_value;
            carry_next = pending_reg;
            cnt_next   = cnt_sat;
            nib_next   = 5'd0;
            rem_next   = number;
            pos_next   = clsq_pkg::DIGIT_POSITIONS - 4'd1;
            acc_next   = 4'd0;
            ovf_next   = 1'b0;
            case (in_kind)
                clsq_pkg::KIND_INIT:
                begin
                    pending_next  = 3'd1;
                    last_idx_next = clsq_pkg::INIT_LAST_IDX;
                end
                clsq_pkg::KIND_NUM:
                begin
                    pending_next  = 3'd0;
                    last_idx_next = {cnt_sat, 1'b0} - 5'd1;
                end
                clsq_pkg::KIND_NONE:
                begin
                    pending_next  = pending_reg;
                    last_idx_next = last_idx_reg;
                end
                default:
                begin
                    pending_next  = 3'd0;
                    last_idx_next = 5'd1;
                end
            endcase
        end
        if (cmd.conv_step)
        begin
            if (ge)
            begin
                rem_next = rem_reg - pow_cur;
                acc_next = acc_reg + 4'd1;
            end
            else
            begin
                ovf_next = ovf_reg || ((acc_reg != 4'd0) && (pos_reg >= cnt_reg));
                acc_next = 4'd0;
                if (pos_reg != 4'd0)
                begin
                    pos_next = pos_reg - 4'd1;
                end
            end
        end
        if (cmd.next_nib)
        begin
            nib_next = nib_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
            kind_reg    <= clsq_pkg::KIND_NONE;
        end
        else
        begin
            pending_reg <= pending_next;
            kind_reg    <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg       <= rs_next;
        byte_reg     <= byte_next;
        carry_reg    <= carry_next;
        cnt_reg      <= cnt_next;
        last_idx_reg <= last_idx_next;
        nib_reg      <= nib_next;
        rem_reg      <= rem_next;
        pos_reg      <= pos_next;
        acc_reg      <= acc_next;
        ovf_reg      <= ovf_next;
        if (cmd.conv_step && !ge && (pos_reg < 4'(MAX_DIGITS)))
        begin
            digit_reg[pos_reg[IDX_W-1:0]] <= acc_reg;
        end
        if (cmd.out_load)
        begin
            out_rs_reg   <= nx_rs;
            out_nib_reg  <= nx_nib;
            out_wait_reg <= nx_wait;
            out_ovf_reg  <= nx_ovf;
            out_last_reg <= is_last;
        end
    end

    assign reg_select = out_rs_reg;
    assign nibble     = out_nib_reg;
    assign wait_ms    = out_wait_reg;
    assign overflow   = out_ovf_reg;
    assign last       = out_last_reg;

endmodule

// File: hdl/char_lcd_4bit_nibble_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_nibble_sequencer: nibble writes for a 4-bit character lcd
// Turns init, command, data, cursor and decimal number requests into a
// sequence of nibble items with register select and the wait before each.
//
// channel  | handshake              | payload
// req      | req_valid / req_ready  | req_type byte_value column row num_digits number
// res      | res_valid / res_ready  | reg_select nibble wait_ms overflow last
//
// one item is taken at a time; each result nibble is registered in a load
// state and then offered in a send state
// decimal numbers first run the conversion loop: one subtraction of a power
// of ten per cycle, moving to the next lower digit position once the remainder is below it
// reset clears the controller and the carried wait
// a stalled result holds the block in its send state until taken
// ----------------------------------------------------------------------------
module char_lcd_4bit_nibble_sequencer
#(
    parameter int MAX_DIGITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  byte_value,
    input  logic [5:0]  column,
    input  logic [2:0]  row,
    input  logic [3:0]  num_digits,
    input  logic [31:0] number,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic [6:0]  wait_ms,
    output logic        overflow,
    output logic        last
);

    clsq_pkg::cmd_t    cmd;
    clsq_pkg::status_t status;

    clsq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .status    (status),
        .cmd       (cmd)
    );

    clsq_datapath
    #(
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_type    (req_type),
        .byte_value  (byte_value),
        .column      (column),
        .row         (row),
        .num_digits  (num_digits),
        .number      (number),
        .reg_select  (reg_select),
        .nibble      (nibble),
        .wait_ms     (wait_ms),
        .overflow    (overflow),
        .last        (last)
    );

endmodule

// File: tb/char_lcd_4bit_nibble_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_nibble_sequencer_test: self-checking bench for the nibble sequencer
// Sends init, command, data, cursor and decimal requests, first from a short
// table of corner cases and then at random, with random gaps on the request
// side and random stalls on the result side. Every nibble item is compared
// field by field with a behavioural model that tracks the carried wait.
// ----------------------------------------------------------------------------
module char_lcd_4bit_nibble_sequencer_test;

    localparam int ITEM_TARGET   = 430;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 120;
    localparam int DIRECTED_ROWS = 26;

    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam logic [3:0] WAKE_NIB        = 4'h3;
    localparam logic [3:0] BUS4_NIB        = 4'h2;
    localparam logic [6:0] POWER_UP_MS     = 7'd115;
    localparam logic [6:0] WAKE_MS         = 7'd5;
    localparam logic [6:0] CLEAR_SETTLE_MS = 7'd4;
    localparam logic [7:0] FUNCTION_SET    = 8'h28;
    localparam logic [7:0] DISPLAY_OFF     = 8'h08;
    localparam logic [7:0] CLEAR_DISPLAY   = 8'h01;
    localparam logic [7:0] ENTRY_MODE      = 8'h06;
    localparam logic [7:0] DISPLAY_ON      = 8'h0C;
    localparam logic [7:0] LINE1_BASE      = 8'h00;
    localparam logic [7:0] LINE2_BASE      = 8'h40;
    localparam logic [7:0] LINE3_BASE      = 8'h14;
    localparam logic [7:0] LINE4_BASE      = 8'h54;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  byte_value;
        logic [5:0]  column;
        logic [2:0]  row;
        logic [3:0]  num_digits;
        logic [31:0] number;
    } lcd_req_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic [6:0] wait_ms;
        logic       overflow;
        logic       last;
    } lcd_nib_t;

    typedef struct packed {
        lcd_req_t req;
        logic     known;
        lcd_nib_t first;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [2:0]  req_type = '0;
    logic [7:0]  byte_value = '0;
    logic [5:0]  column = '0;
    logic [2:0]  row = '0;
    logic [3:0]  num_digits = '0;
    logic [31:0] number = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [6:0]  wait_ms;
    logic        overflow;
    logic        last;

    lcd_nib_t expected_nibbles[$];
    lcd_nib_t fresh_nibbles[$];
    lcd_nib_t want_nib;
    logic [2:0] carried_wait = '0;

    int  error_count = 0;
    int  nibbles_checked = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;
    int  n_init = 0;
    int  n_cmd = 0;
    int  n_data = 0;
    int  n_cursor = 0;
    int  n_num = 0;
    int  n_overflow = 0;
    int  n_ignored = 0;

    char_lcd_4bit_nibble_sequencer #(.MAX_DIGITS(clsq_pkg::DIGIT_POSITIONS)) dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .byte_value  (byte_value),
        .column      (column),
        .row         (row),
        .num_digits  (num_digits),
        .number      (number),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .reg_select  (reg_select),
        .nibble      (nibble),
        .wait_ms     (wait_ms),
        .overflow    (overflow),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // nibble prediction
    // ------------------------------------------------------------------
    function automatic void push_nibble(logic rs, logic [3:0] nib, logic [6:0] ms, logic ovf);
        lcd_nib_t e;
        e.reg_select = rs;
        e.nibble     = nib;
        e.wait_ms    = ms;
        e.overflow   = ovf;
        e.last       = 1'b0;
        fresh_nibbles.push_back(e);
    endfunction

    // high nibble first, after 1 ms plus any extra owed
    function automatic void push_byte(logic rs, logic [7:0] b, logic [6:0] extra, logic ovf);
        push_nibble(rs, b[7:4], 7'd1 + extra, ovf);
        push_nibble(rs, b[3:0], 7'd0, ovf);
    endfunction

    function automatic void predict_nibbles(lcd_req_t r);
        logic [6:0]  carry_ms;
        logic [7:0]  base;
        logic [7:0]  addr_cmd;
        logic [3:0]  digits;
        logic [3:0]  dig;
        logic [63:0] limit;
        logic [63:0] scale;
        logic        ovf;
        lcd_nib_t    tail;
        fresh_nibbles.delete();
        carry_ms = {4'b0, carried_wait};
        case (r.req_type)
            clsq_pkg::REQ_INIT:
            begin
                // power-up wait swallows whatever was owed
                push_nibble(1'b0, WAKE_NIB, POWER_UP_MS, 1'b0);
                push_nibble(1'b0, WAKE_NIB, WAKE_MS, 1'b0);
                push_nibble(1'b0, WAKE_NIB, WAKE_MS, 1'b0);
                push_nibble(1'b0, BUS4_NIB, WAKE_MS, 1'b0);
                push_byte(1'b0, FUNCTION_SET, 7'd0, 1'b0);
                push_byte(1'b0, DISPLAY_OFF, 7'd0, 1'b0);
                push_byte(1'b0, CLEAR_DISPLAY, 7'd0, 1'b0);
                push_byte(1'b0, ENTRY_MODE, CLEAR_SETTLE_MS, 1'b0);
                push_byte(1'b0, DISPLAY_ON, 7'd0, 1'b0);
            end
            clsq_pkg::REQ_CMD:
                push_byte(1'b0, r.byte_value, carry_ms, 1'b0);
            clsq_pkg::REQ_DATA:
                push_byte(1'b1, r.byte_value, carry_ms, 1'b0);
            clsq_pkg::REQ_CURSOR:
            begin
                case (r.row)
                    3'd2:    base = LINE2_BASE;
                    3'd3:    base = LINE3_BASE;
                    3'd4:    base = LINE4_BASE;
                    default: base = LINE1_BASE;
                endcase
                addr_cmd = clsq_pkg::DDRAM_SET_ADDR | (base + {2'b0, r.column} - 8'd1);
                push_byte(1'b0, addr_cmd, carry_ms, 1'b0);
            end
            clsq_pkg::REQ_NUM:
            begin
                digits = (r.num_digits > clsq_pkg::DIGIT_POSITIONS) ? clsq_pkg::DIGIT_POSITIONS
                                                                    : r.num_digits;
                limit = 64'd1;
                repeat (digits) limit = limit * 64'd10;
                ovf = ({32'b0, r.number} >= limit);
                for (int i = int'(digits) - 1; i >= 0; i--)
                begin
                    scale = 64'd1;
                    repeat (i) scale = scale * 64'd10;
                    dig = 4'(({32'b0, r.number} / scale) % 64'd10);
                    push_byte(1'b1, {clsq_pkg::ASCII_DIGIT_HI, dig},
                              (i == int'(digits) - 1) ? carry_ms : 7'd0, ovf);
                end
            end
            default: ;
        endcase
        if (fresh_nibbles.size() > 0)
        begin
            tail = fresh_nibbles.pop_back();
            tail.last = 1'b1;
            fresh_nibbles.push_back(tail);
            carried_wait = (r.req_type == clsq_pkg::REQ_INIT) ? 3'd1 : 3'd0;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic stim_row_t table_row(logic [2:0] kind, logic [7:0] b, logic [5:0] col,
                                            logic [2:0] rw, logic [3:0] cnt, logic [31:0] num,
                                            logic known, logic rs, logic [3:0] nib,
                                            logic [6:0] ms, logic ovf);
        stim_row_t s;
        s.req   = '{req_type: kind, byte_value: b, column: col, row: rw,
                    num_digits: cnt, number: num};
        s.known = known;
        s.first = '{reg_select: rs, nibble: nib, wait_ms: ms, overflow: ovf, last: 1'b0};
        return s;
    endfunction

    function automatic stim_row_t directed_row(int idx);
        stim_row_t s;
        s = '0;
        case (idx)
            0:  s = table_row(clsq_pkg::REQ_INIT,   8'h00, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b1, 1'b0, 4'h3, 7'd115, 1'b0);
            1:  s = table_row(clsq_pkg::REQ_CMD,    8'h00, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b1, 1'b0, 4'h0, 7'd2,   1'b0);
            2:  s = table_row(clsq_pkg::REQ_DATA,   8'hFF, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b1, 1'b1, 4'hF, 7'd1,   1'b0);
            3:  s = table_row(clsq_pkg::REQ_DATA,   8'h00, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            4:  s = table_row(clsq_pkg::REQ_CMD,    8'hA5, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            5:  s = table_row(clsq_pkg::REQ_CURSOR, 8'h00, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b1, 1'b0, 4'h8, 7'd1,   1'b0);
            6:  s = table_row(clsq_pkg::REQ_CURSOR, 8'h00, 6'd40, 3'd2, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            7:  s = table_row(clsq_pkg::REQ_CURSOR, 8'h00, 6'd20, 3'd3, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            8:  s = table_row(clsq_pkg::REQ_CURSOR, 8'h00, 6'd20, 3'd4, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            9:  s = table_row(clsq_pkg::REQ_CURSOR, 8'h00, 6'd63, 3'd7, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            10: s = table_row(clsq_pkg::REQ_CURSOR, 8'h00, 6'd0,  3'd4, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            11: s = table_row(clsq_pkg::REQ_CURSOR, 8'h00, 6'd0,  3'd0, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            12: s = table_row(clsq_pkg::REQ_NUM,    8'h00, 6'd1,  3'd0, 4'd10, 32'hFFFF_FFFF,
                              1'b1, 1'b1, 4'h3, 7'd1,   1'b0);
            13: s = table_row(clsq_pkg::REQ_NUM,    8'h00, 6'd1,  3'd0, 4'd3,  32'd12345,
                              1'b1, 1'b1, 4'h3, 7'd1,   1'b1);
            14: s = table_row(clsq_pkg::REQ_NUM,    8'h00, 6'd1,  3'd0, 4'd0,  32'd7,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            15: s = table_row(clsq_pkg::REQ_INIT,   8'h00, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b1, 1'b0, 4'h3, 7'd115, 1'b0);
            // zero digits and spare codes must leave the owed wait alone
            16: s = table_row(clsq_pkg::REQ_NUM,    8'hFF, 6'd63, 3'd7, 4'd0,  32'hFFFF_FFFF,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            17: s = table_row(REQ_SPARE_LO, 8'hFF, 6'd63, 3'd7, 4'd15, 32'hFFFF_FFFF,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            18: s = table_row(REQ_SPARE_HI, 8'h00, 6'd0, 3'd0, 4'd0,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            19: s = table_row(clsq_pkg::REQ_DATA,   8'h41, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b1, 1'b1, 4'h4, 7'd2,   1'b0);
            20: s = table_row(clsq_pkg::REQ_INIT,   8'h00, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            21: s = table_row(clsq_pkg::REQ_INIT,   8'h00, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b1, 1'b0, 4'h3, 7'd115, 1'b0);
            22: s = table_row(clsq_pkg::REQ_NUM,    8'h00, 6'd1,  3'd0, 4'd15, 32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            23: s = table_row(clsq_pkg::REQ_NUM,    8'h00, 6'd1,  3'd0, 4'd1,  32'd9,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            24: s = table_row(clsq_pkg::REQ_NUM,    8'h00, 6'd1,  3'd0, 4'd1,  32'd10,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
            default:
                s = table_row(clsq_pkg::REQ_CMD,    8'hFF, 6'd1,  3'd0, 4'd1,  32'd0,
                              1'b0, 1'b0, 4'h0, 7'd0,   1'b0);
        endcase
        return s;
    endfunction

    function automatic lcd_req_t random_request();
        lcd_req_t    r;
        int          pick;
        logic [31:0] p;
        r.byte_value = 8'($urandom);
        r.column = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(1, 40));
        r.row = 3'($urandom_range(0, 7));
        r.num_digits = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(11, 15))
                                                   : 4'($urandom_range(1, 10));
        case ($urandom_range(0, 3))
            0: r.number = $urandom_range(0, 99);
            1: r.number = $urandom;
            2:
            begin
                // either side of a power of ten
                p = 32'd1;
                repeat ($urandom_range(1, 9)) p = p * 32'd10;
                r.number = p - 32'($urandom_range(0, 1));
            end
            default: r.number = $urandom_range(0, 99999);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.req_type = clsq_pkg::REQ_INIT;
        else if (pick < 20)
            r.req_type = clsq_pkg::REQ_CMD;
        else if (pick < 45)
            r.req_type = clsq_pkg::REQ_DATA;
        else if (pick < 65)
            r.req_type = clsq_pkg::REQ_CURSOR;
        else if (pick < 95)
            r.req_type = clsq_pkg::REQ_NUM;
        else if (pick < 97)
        begin
            r.req_type = clsq_pkg::REQ_NUM;
            r.num_digits = '0;
        end
        else
            r.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        return r;
    endfunction

    // drive one request, wait for it to be taken, then queue its nibbles
    task automatic play_request(input lcd_req_t r, input logic known, input lcd_nib_t first,
                                output int produced);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= r.req_type;
        byte_value  <= r.byte_value;
        column      <= r.column;
        row         <= r.row;
        num_digits  <= r.num_digits;
        number      <= r.number;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        predict_nibbles(r);
        produced = fresh_nibbles.size();
        if (known && produced > 0)
            fresh_nibbles[0] = first;
        foreach (fresh_nibbles[i]) expected_nibbles.push_back(fresh_nibbles[i]);
        if (produced == 0)
            n_ignored++;
        else
            case (r.req_type)
                clsq_pkg::REQ_INIT:   n_init++;
                clsq_pkg::REQ_CMD:    n_cmd++;
                clsq_pkg::REQ_DATA:   n_data++;
                clsq_pkg::REQ_CURSOR: n_cursor++;
                default:
                begin
                    n_num++;
                    if (fresh_nibbles[0].overflow)
                        n_overflow++;
                end
            endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t s;
        lcd_req_t  r;
        int        produced;
        int        useful;
        bit        paused;
        useful = 0;
        paused = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int idx = 0; idx < DIRECTED_ROWS; idx++)
        begin
            s = directed_row(idx);
            play_request(s.req, s.known, s.first, produced);
            if (produced > 0)
                useful++;
        end

        while (useful < ITEM_TARGET)
        begin
            if (!paused && useful >= ITEM_TARGET / 2)
            begin
                // hold off until the block has drained completely
                paused = 1'b1;
                req_valid <= 1'b0;
                @(posedge clk);
                while (expected_nibbles.size() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                calm = ($urandom_range(0, 2) == 0);
            r = random_request();
            play_request(r, 1'b0, '0, produced);
            if (produced > 0)
                useful++;
        end
        req_valid <= 1'b0;

        while (expected_nibbles.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d init, %0d command, %0d data, %0d cursor and %0d number requests",
                 n_init, n_cmd, n_data, n_cursor, n_num);
        $display("%0d numbers overflowed, %0d requests ignored, %0d nibble items checked",
                 n_overflow, n_ignored, nibbles_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            res_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            if (expected_nibbles.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected item, expected none actual rs=%0b nib=%h",
                         $time, reg_select, nibble);
                $display("%0t:   wait=%0d ovf=%0b last=%0b",
                         $time, wait_ms, overflow, last);
            end
            else
            begin
                want_nib = expected_nibbles.pop_front();
                nibbles_checked++;
                compare_field("reg_select", int'(want_nib.reg_select), int'(reg_select));
                compare_field("nibble", int'(want_nib.nibble), int'(nibble));
                compare_field("wait_ms", int'(want_nib.wait_ms), int'(wait_ms));
                compare_field("overflow", int'(want_nib.overflow), int'(overflow));
                compare_field("last", int'(want_nib.last), int'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
